### rtl/core/rgpg_pkg.sv
// shared types, constants and register codes for the rgb gradient pixel generator
`default_nettype none

package rgpg_pkg;

  // field widths
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 13;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int PAD_W      = 2;
  localparam int BYTE_CNT_W = 3;

  // datapath widths: divisor is at most h*w, geometry term at most y*w + x*h
  localparam int PROD_W = 2 * DIM_W;
  localparam int GEO_W  = PROD_W + 1;
  localparam int QUO_W  = 8;
  localparam int MAG_W  = GEO_W + QUO_W;
  localparam int DSH_W  = PROD_W + QUO_W - 1;

  // pixel queue between front and back, power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // size limits
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // register reset values
  localparam logic [COLOR_W-1:0] START_RST  = 24'hFF0000;
  localparam logic [COLOR_W-1:0] TARGET_RST = 24'h787CA0;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd512;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd1024;
  localparam logic [DIR_W-1:0]   DIR_RST    = 2'd1;

  // direction codes: bit 1 set selects column mode
  localparam logic [DIR_W-1:0] DIR_DIAG    = 2'd1;
  localparam int               DIR_COL_BIT = 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR  = 3'd0,
    REG_TARGET_COLOR = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_DIRECTION    = 3'd4
  } cfg_reg_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GEOM,
    BK_SCALE,
    BK_START,
    BK_DIV,
    BK_WAIT
  } back_state_t;

  // one classified pixel
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             row_end;
    logic             frame_end;
    logic [PAD_W-1:0] pad;
  } pix_t;

  // effective frame size
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } geom_t;

  // color settings seen by the back end
  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] target_color;
    logic [DIR_W-1:0]   direction;
  } color_cfg_t;

  // divider status
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic             rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

### rtl/core/rgpg_front.sv
// front end: takes input transactions, tracks scan position and classifies each pixel
`default_nettype none

module rgpg_front #(
  parameter int unsigned MAX_WIDTH  = rgpg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rgpg_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_frame_restart,
  input  wire logic [rgpg_pkg::DIM_W-1:0]   image_width,
  input  wire logic [rgpg_pkg::DIM_W-1:0]   image_height,
  input  wire logic                         fifo_full,
  output logic                              push,
  output rgpg_pkg::pix_t                    push_data,
  output rgpg_pkg::geom_t                   geom
);

  localparam int POS_W = rgpg_pkg::POS_W;
  localparam int DIM_W = rgpg_pkg::DIM_W;

  logic [POS_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [POS_W-1:0] x_base, y_base, x_cur, y_cur, x_inc, y_inc;
  logic             row_end, frame_end;
  rgpg_pkg::geom_t  geom_c;

  // effective size: zero reads as one, oversize clamps to the limit
  always_comb begin
    if (image_width == '0) begin
      geom_c.w = DIM_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      geom_c.w = DIM_W'(MAX_WIDTH);
    end else begin
      geom_c.w = image_width;
    end
    if (image_height == '0) begin
      geom_c.h = DIM_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      geom_c.h = DIM_W'(MAX_HEIGHT);
    end else begin
      geom_c.h = image_height;
    end
  end

  assign geom = geom_c;

  // take a transaction whenever the queue has room
  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  // position of this pixel after restart and range fixups
  always_comb begin
    x_base    = in_frame_restart ? '0 : x_r;
    y_base    = in_frame_restart ? '0 : y_r;
    x_cur     = (x_base >= POS_W'(geom_c.w)) ? '0 : x_base;
    y_cur     = (y_base >= POS_W'(geom_c.h)) ? '0 : y_base;
    x_inc     = x_cur + POS_W'(1);
    y_inc     = y_cur + POS_W'(1);
    row_end   = (x_inc == POS_W'(geom_c.w));
    frame_end = row_end && (y_inc == POS_W'(geom_c.h));
  end

  // pad count (4 - 3w mod 4) mod 4 equals w mod 4
  always_comb begin
    push_data.x         = x_cur;
    push_data.y         = y_cur;
    push_data.row_end   = row_end;
    push_data.frame_end = frame_end;
    push_data.pad       = geom_c.w[rgpg_pkg::PAD_W-1:0];
  end

  // advance scan position
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (push) begin
      if (row_end) begin
        x_nxt = '0;
        y_nxt = frame_end ? '0 : y_inc;
      end else begin
        x_nxt = x_inc;
        y_nxt = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rgpg_fifo.sv
// short pixel queue between front and back end
`default_nettype none

module rgpg_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rgpg_pkg::pix_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output rgpg_pkg::pix_t       pop_data,
  output logic                 empty
);

  localparam int DEPTH = rgpg_pkg::FIFO_DEPTH;
  localparam int AW    = rgpg_pkg::FIFO_AW;

  rgpg_pkg::pix_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("pixel queue pushed while full");

endmodule

`default_nettype wire

### rtl/core/rgpg_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit in eight bits
`default_nettype none

module rgpg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [rgpg_pkg::MAG_W-1:0]    num,
  input  wire logic [rgpg_pkg::PROD_W-1:0]   den,
  output rgpg_pkg::div_res_t                 res
);

  localparam int MAG_W = rgpg_pkg::MAG_W;
  localparam int DSH_W = rgpg_pkg::DSH_W;
  localparam int QUO_W = rgpg_pkg::QUO_W;
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt, rem_step;
  logic [DSH_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             ge;

  // one trial subtraction
  always_comb begin
    ge       = (rem_r >= MAG_W'(dsh_r));
    rem_step = ge ? rem_r - MAG_W'(dsh_r) : rem_r;
  end

  // load on start, then step down from the top quotient bit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      dsh_nxt  = {den, (QUO_W-1)'(0)};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      dsh_nxt = dsh_r >> 1;
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    res.done   = done_r;
    res.quo    = quo_r;
    res.rem_nz = |rem_r;
  end

endmodule

`default_nettype wire

### rtl/core/rgpg_back.sv
// back end: computes the three channel bytes of a pixel and streams them out with padding
`default_nettype none

module rgpg_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rgpg_pkg::color_cfg_t         cfg,
  input  wire rgpg_pkg::geom_t              geom,
  input  wire logic                         fifo_empty,
  output logic                              pop,
  input  wire rgpg_pkg::pix_t               pop_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [rgpg_pkg::CH_W-1:0]         out_data_byte,
  output logic                              out_last_of_run,
  output logic                              out_end_of_row,
  output logic                              out_end_of_frame
);

  localparam int NUM_CH     = rgpg_pkg::NUM_CH;
  localparam int CH_W       = rgpg_pkg::CH_W;
  localparam int DIFF_W     = CH_W + 1;
  localparam int GEO_W      = rgpg_pkg::GEO_W;
  localparam int PROD_W     = rgpg_pkg::PROD_W;
  localparam int MAG_W      = rgpg_pkg::MAG_W;
  localparam int BYTE_CNT_W = rgpg_pkg::BYTE_CNT_W;
  localparam logic [BYTE_CNT_W-1:0] PIX_LAST = BYTE_CNT_W'(NUM_CH - 1);

  rgpg_pkg::back_state_t state_r, state_nxt;
  rgpg_pkg::pix_t        ent_r, ent_nxt;
  rgpg_pkg::div_res_t    div_res [NUM_CH];

  logic              is_diag, is_col;
  logic              div_start, em_load, em_step, em_is_last;
  logic [PROD_W-1:0] prod_yw, prod_xh, prod_hw;
  logic [GEO_W-1:0]  geo_c, geo_r, geo_nxt;
  logic [PROD_W-1:0] den_c, den_r, den_nxt;

  logic [CH_W-1:0]   s_ch     [NUM_CH];
  logic [CH_W-1:0]   t_ch     [NUM_CH];
  logic [DIFF_W-1:0] d_ch     [NUM_CH];
  logic [DIFF_W-1:0] d_adj    [NUM_CH];
  logic [DIFF_W-1:0] f_ch     [NUM_CH];
  logic [DIFF_W-1:0] f_neg    [NUM_CH];
  logic [CH_W-1:0]   fmag_ch  [NUM_CH];
  logic [MAG_W-1:0]  mag_c    [NUM_CH];
  logic [MAG_W-1:0]  mag_r    [NUM_CH];
  logic [MAG_W-1:0]  mag_nxt  [NUM_CH];
  logic              neg_r    [NUM_CH];
  logic              neg_nxt  [NUM_CH];
  logic [CH_W-1:0]   res_byte [NUM_CH];
  logic [CH_W-1:0]   byte_r   [NUM_CH];
  logic [CH_W-1:0]   byte_nxt [NUM_CH];

  logic                  em_busy_r, em_busy_nxt;
  logic [BYTE_CNT_W-1:0] em_k_r, em_k_nxt, em_last_r, em_last_nxt;
  logic                  em_row_r, em_row_nxt, em_frame_r, em_frame_nxt;
  logic [CH_W-1:0]       em_byte_r   [NUM_CH];
  logic [CH_W-1:0]       em_byte_nxt [NUM_CH];

  assign is_diag = (cfg.direction == rgpg_pkg::DIR_DIAG);
  assign is_col  = cfg.direction[rgpg_pkg::DIR_COL_BIT];

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgpg_pkg::BK_IDLE: begin
        if (!fifo_empty) state_nxt = rgpg_pkg::BK_GEOM;
      end
      rgpg_pkg::BK_GEOM:  state_nxt = rgpg_pkg::BK_SCALE;
      rgpg_pkg::BK_SCALE: state_nxt = rgpg_pkg::BK_START;
      rgpg_pkg::BK_START: state_nxt = rgpg_pkg::BK_DIV;
      rgpg_pkg::BK_DIV: begin
        if (div_res[0].done) state_nxt = rgpg_pkg::BK_WAIT;
      end
      rgpg_pkg::BK_WAIT: begin
        if (!em_busy_r) state_nxt = rgpg_pkg::BK_IDLE;
      end
      default: state_nxt = rgpg_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    em_load   = 1'b0;
    case (state_r)
      rgpg_pkg::BK_IDLE:  pop       = !fifo_empty;
      rgpg_pkg::BK_START: div_start = 1'b1;
      rgpg_pkg::BK_WAIT:  em_load   = !em_busy_r;
      default: begin
        pop       = 1'b0;
        div_start = 1'b0;
        em_load   = 1'b0;
      end
    endcase
  end

  // geometry term and divisor for the selected direction
  always_comb begin
    prod_yw = ent_r.y * geom.w;
    prod_xh = ent_r.x * geom.h;
    prod_hw = geom.h * geom.w;
    if (is_col) begin
      geo_c = GEO_W'(ent_r.x);
      den_c = PROD_W'(geom.w);
    end else if (is_diag) begin
      geo_c = {1'b0, prod_yw} + {1'b0, prod_xh};
      den_c = prod_hw;
    end else begin
      geo_c = GEO_W'(ent_r.y);
      den_c = PROD_W'(geom.h);
    end
  end

  // per channel delta, halved toward zero in diagonal mode, and scaled magnitude
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s_ch[c]    = cfg.start_color[c*CH_W +: CH_W];
      t_ch[c]    = cfg.target_color[c*CH_W +: CH_W];
      d_ch[c]    = {1'b0, s_ch[c]} - {1'b0, t_ch[c]};
      d_adj[c]   = d_ch[c] + {{CH_W{1'b0}}, d_ch[c][DIFF_W-1]};
      f_ch[c]    = is_diag ? {d_adj[c][DIFF_W-1], d_adj[c][DIFF_W-1:1]} : d_ch[c];
      f_neg[c]   = ~f_ch[c] + DIFF_W'(1);
      fmag_ch[c] = f_ch[c][DIFF_W-1] ? f_neg[c][CH_W-1:0] : f_ch[c][CH_W-1:0];
      mag_c[c]   = geo_r * fmag_ch[c];
    end
  end

  // floor of start minus the signed ratio
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (neg_r[c]) begin
        res_byte[c] = s_ch[c] + div_res[c].quo;
      end else begin
        res_byte[c] = s_ch[c] - div_res[c].quo - {{(CH_W-1){1'b0}}, div_res[c].rem_nz};
      end
    end
  end

  // datapath register updates
  always_comb begin
    ent_nxt = pop ? pop_data : ent_r;
    geo_nxt = (state_r == rgpg_pkg::BK_GEOM) ? geo_c : geo_r;
    den_nxt = (state_r == rgpg_pkg::BK_GEOM) ? den_c : den_r;
    for (int c = 0; c < NUM_CH; c++) begin
      mag_nxt[c]  = (state_r == rgpg_pkg::BK_SCALE) ? mag_c[c] : mag_r[c];
      neg_nxt[c]  = (state_r == rgpg_pkg::BK_SCALE) ? f_ch[c][DIFF_W-1] : neg_r[c];
      byte_nxt[c] = (state_r == rgpg_pkg::BK_DIV && div_res[0].done) ? res_byte[c]
                                                                      : byte_r[c];
    end
  end

  // one divider per channel, all started together
  for (genvar g = 0; g < NUM_CH; g++) begin : g_div
    rgpg_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (mag_r[g]),
      .den   (den_r),
      .res   (div_res[g])
    );
  end

  // byte emitter: channel bytes then zero padding at row end
  assign em_is_last = (em_k_r == em_last_r);
  assign em_step    = em_busy_r && !out_stall;

  always_comb begin
    em_busy_nxt  = em_busy_r;
    em_k_nxt     = em_k_r;
    em_last_nxt  = em_last_r;
    em_row_nxt   = em_row_r;
    em_frame_nxt = em_frame_r;
    for (int c = 0; c < NUM_CH; c++) begin
      em_byte_nxt[c] = em_byte_r[c];
    end
    if (em_load) begin
      em_busy_nxt  = 1'b1;
      em_k_nxt     = '0;
      em_last_nxt  = PIX_LAST + (ent_r.row_end ? BYTE_CNT_W'(ent_r.pad) : '0);
      em_row_nxt   = ent_r.row_end;
      em_frame_nxt = ent_r.frame_end;
      for (int c = 0; c < NUM_CH; c++) begin
        em_byte_nxt[c] = byte_r[c];
      end
    end else if (em_step) begin
      if (em_is_last) begin
        em_busy_nxt = 1'b0;
      end else begin
        em_k_nxt = em_k_r + BYTE_CNT_W'(1);
      end
    end
  end

  // result channel
  always_comb begin
    out_valid        = em_busy_r;
    out_data_byte    = (em_k_r <= PIX_LAST) ? em_byte_r[em_k_r[1:0]] : '0;
    out_last_of_run  = em_is_last;
    out_end_of_row   = em_is_last && em_row_r;
    out_end_of_frame = em_is_last && em_frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rgpg_pkg::BK_IDLE;
      em_busy_r <= 1'b0;
      em_k_r    <= '0;
      em_last_r <= PIX_LAST;
    end else begin
      state_r   <= state_nxt;
      em_busy_r <= em_busy_nxt;
      em_k_r    <= em_k_nxt;
      em_last_r <= em_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    geo_r      <= geo_nxt;
    den_r      <= den_nxt;
    em_row_r   <= em_row_nxt;
    em_frame_r <= em_frame_nxt;
    for (int c = 0; c < NUM_CH; c++) begin
      mag_r[c]     <= mag_nxt[c];
      neg_r[c]     <= neg_nxt[c];
      byte_r[c]    <= byte_nxt[c];
      em_byte_r[c] <= em_byte_nxt[c];
    end
  end

  // byte index never runs past the last byte of the run
  a_k_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    em_busy_r |-> em_k_r <= em_last_r)
    else $error("emitter index beyond run length");

  // divider results arrive only while the sequencer waits for them
  a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_res[0].done |-> state_r == rgpg_pkg::BK_DIV)
    else $error("divider finished outside divide state");

  // all channel dividers finish in the same cycle
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_res[0].done |-> (div_res[1].done && div_res[NUM_CH-1].done))
    else $error("channel dividers out of step");

  // emitter is loaded only from the hand-over state
  a_load_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(em_busy_r) |-> $past(state_r) == rgpg_pkg::BK_WAIT)
    else $error("emitter started without a finished pixel");

endmodule

`default_nettype wire

### rtl/core/rgb_gradient_pixel_generator_core.sv
// Gradient pixel generator: an accepted transaction yields 3 to 6 byte transactions.
// The first byte follows the queue, the GEOM, SCALE, START and DIV states and the hand-over in WAIT.
// The pixel rate is set by the 8-step restoring dividers of the back end plus setup; pixels are
// computed one at a time, and a pixel's bytes stream out while the next pixel is computed.
// Reset (rst_n low, synchronous): position returns to pixel 0,0, queue and emitter empty,
// registers take their default values.
`default_nettype none

module rgb_gradient_pixel_generator_core #(
  parameter int unsigned MAX_WIDTH  = rgpg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rgpg_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_frame_restart,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rgpg_pkg::CH_W-1:0]             out_data_byte,
  output logic                                  out_last_of_run,
  output logic                                  out_end_of_row,
  output logic                                  out_end_of_frame,
  input  wire logic                             cfg_we,
  input  wire logic [rgpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rgpg_pkg::COLOR_W-1:0]     cfg_data
);

  localparam int COLOR_W = rgpg_pkg::COLOR_W;
  localparam int DIM_W   = rgpg_pkg::DIM_W;
  localparam int DIR_W   = rgpg_pkg::DIR_W;

  logic [COLOR_W-1:0] start_r, start_nxt, target_r, target_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt, height_r, height_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;

  rgpg_pkg::color_cfg_t color_cfg;
  rgpg_pkg::geom_t      geom;
  rgpg_pkg::pix_t       push_data, pop_data;
  logic                 push, pop, fifo_full, fifo_empty;

  // register file writes, unknown indexes ignored
  always_comb begin
    start_nxt  = start_r;
    target_nxt = target_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    dir_nxt    = dir_r;
    if (cfg_we) begin
      case (rgpg_pkg::cfg_reg_t'(cfg_index))
        rgpg_pkg::REG_START_COLOR:  start_nxt  = cfg_data;
        rgpg_pkg::REG_TARGET_COLOR: target_nxt = cfg_data;
        rgpg_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data[DIM_W-1:0];
        rgpg_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data[DIM_W-1:0];
        rgpg_pkg::REG_DIRECTION:    dir_nxt    = cfg_data[DIR_W-1:0];
        default: begin
          start_nxt = start_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= rgpg_pkg::START_RST;
      target_r <= rgpg_pkg::TARGET_RST;
      width_r  <= rgpg_pkg::WIDTH_RST;
      height_r <= rgpg_pkg::HEIGHT_RST;
      dir_r    <= rgpg_pkg::DIR_RST;
    end else begin
      start_r  <= start_nxt;
      target_r <= target_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_comb begin
    color_cfg.start_color  = start_r;
    color_cfg.target_color = target_r;
    color_cfg.direction    = dir_r;
  end

  // scan position and pixel classification
  rgpg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_restart (in_frame_restart),
    .image_width      (width_r),
    .image_height     (height_r),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_data        (push_data),
    .geom             (geom)
  );

  // pixel queue
  rgpg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // color math and byte stream
  rgpg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (color_cfg),
    .geom             (geom),
    .fifo_empty       (fifo_empty),
    .pop              (pop),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire

### tb/rgpg_checker.sv
// checker for the gradient generator: predicts byte transactions per pixel and compares them
module rgpg_checker import rgpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_frame_restart,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CH_W-1:0]      out_data_byte,
  input  logic                 out_last_of_run,
  input  logic                 out_end_of_row,
  input  logic                 out_end_of_frame,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int                   mismatch_count,
  output int                   bytes_outstanding
);

  // one predicted byte transaction
  typedef struct packed {
    logic [CH_W-1:0] data;
    logic            last;
    logic            row_end;
    logic            frame_end;
  } gradient_byte_t;

  gradient_byte_t     pending_bytes[$];

  // shadow copy of the registers and scan position
  logic [COLOR_W-1:0] start_shadow;
  logic [COLOR_W-1:0] target_shadow;
  logic [DIM_W-1:0]   width_shadow;
  logic [DIM_W-1:0]   height_shadow;
  logic [DIR_W-1:0]   dir_shadow;
  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   row_pos;

  initial begin
    mismatch_count    = 0;
    bytes_outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // floor of n/d for d > 0
  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // zero size acts as one, oversize clips to the limit
  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return DIM_W'(1);
    if (v > lim) return DIM_W'(lim);
    return v;
  endfunction

  // one color channel of the gradient at (x, y)
  function automatic logic [CH_W-1:0] gradient_channel(input int sh, input longint x,
                                                       input longint y, input longint w,
                                                       input longint h);
    longint s, t, d, hd, v;
    s = longint'(start_shadow[sh +: CH_W]);
    t = longint'(target_shadow[sh +: CH_W]);
    d = s - t;
    if (dir_shadow[DIR_COL_BIT]) begin
      v = floor_quot(s * w - x * d, w);
    end else if (dir_shadow == DIR_DIAG) begin
      hd = d / 2;
      v = floor_quot(s * h * w - hd * (y * w + x * h), h * w);
    end else begin
      v = floor_quot(s * h - y * d, h);
    end
    return v[CH_W-1:0];
  endfunction

  // expected bytes of one pixel, pad bytes included, then advance the scan
  task automatic predict_pixel(input logic restart);
    logic [DIM_W-1:0] w, h;
    logic [CH_W-1:0]  px[NUM_CH];
    logic             row_end, frame_end;
    int               pad, n;
    gradient_byte_t   b;
    w = fit_dim(width_shadow, MAX_WIDTH_DEF);
    h = fit_dim(height_shadow, MAX_HEIGHT_DEF);
    if (restart) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (col_pos >= w) col_pos = '0;
    if (row_pos >= h) row_pos = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      px[c] = gradient_channel(c * CH_W, longint'(col_pos), longint'(row_pos),
                               longint'(w), longint'(h));
    end
    row_end   = (col_pos + 1 == w);
    frame_end = row_end && (row_pos + 1 == h);
    pad       = row_end ? (4 - (3 * w) % 4) % 4 : 0;
    n         = NUM_CH + pad;
    for (int k = 0; k < n; k++) begin
      b.data      = (k < NUM_CH) ? px[k] : '0;
      b.last      = (k == n - 1);
      b.row_end   = b.last && row_end;
      b.frame_end = b.last && frame_end;
      pending_bytes.push_back(b);
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? '0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // compare one accepted byte transaction with the oldest prediction
  task automatic check_byte();
    gradient_byte_t want;
    if (pending_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h", out_data_byte));
    end else begin
      want = pending_bytes.pop_front();
      if (out_data_byte !== want.data || out_last_of_run !== want.last ||
          out_end_of_row !== want.row_end || out_end_of_frame !== want.frame_end) begin
        report_mismatch($sformatf("byte %02h last %b row %b frame %b, want %02h %b %b %b",
                                  out_data_byte, out_last_of_run, out_end_of_row,
                                  out_end_of_frame, want.data, want.last, want.row_end,
                                  want.frame_end));
      end
    end
  endtask

  // register write into the shadow copy, unknown indexes ignored
  task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] v);
    case (cfg_reg_t'(idx))
      REG_START_COLOR:  start_shadow  = v;
      REG_TARGET_COLOR: target_shadow = v;
      REG_IMAGE_WIDTH:  width_shadow  = v[DIM_W-1:0];
      REG_IMAGE_HEIGHT: height_shadow = v[DIM_W-1:0];
      REG_DIRECTION:    dir_shadow    = v[DIR_W-1:0];
      default: ;
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      start_shadow  = START_RST;
      target_shadow = TARGET_RST;
      width_shadow  = WIDTH_RST;
      height_shadow = HEIGHT_RST;
      dir_shadow    = DIR_RST;
      col_pos       = '0;
      row_pos       = '0;
      pending_bytes.delete();
    end else begin
      if (out_valid && !out_stall) check_byte();
      if (in_valid && !in_stall) predict_pixel(in_frame_restart);
      if (cfg_we) shadow_write(cfg_index, cfg_data);
    end
    bytes_outstanding <= pending_bytes.size();
  end

endmodule

### tb/tb_top.sv
// testbench top for the gradient generator: clock, reset, stimulus and verdict
module tb_top;
  import rgpg_pkg::*;

  localparam logic [DIR_W-1:0]     DIR_ROW         = 2'd0;
  localparam logic [DIR_W-1:0]     DIR_COL         = 2'd2;
  localparam logic [DIR_W-1:0]     DIR_COL_ALIAS   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LAST  = 3'd7;
  localparam int                   RAND_PHASES     = 12;
  localparam int                   PHASE_PIXELS    = 17;
  localparam int                   PRESSURE_PHASE  = 9;
  localparam int                   HOLD_CYCLES     = 300;
  localparam int                   RESTART_PCT     = 8;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_frame_restart = 1'b0;
  logic                 out_stall        = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [COLOR_W-1:0]   cfg_data         = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [CH_W-1:0]      out_data_byte;
  logic                 out_last_of_run;
  logic                 out_end_of_row;
  logic                 out_end_of_frame;
  int                   mismatch_count;
  int                   bytes_outstanding;

  int send_idle_pct = 19;
  int recv_idle_pct = 51;
  int phase_id      = -1;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  always #1 clk = ~clk;

  rgb_gradient_pixel_generator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_restart (in_frame_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  rgpg_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_frame_restart  (in_frame_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_row    (out_end_of_row),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .bytes_outstanding (bytes_outstanding)
  );

  // byte receiver: random stall, plus one long hold-off in the pressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase_id == PRESSURE_PHASE) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // wait until every predicted byte transaction has been taken
  task automatic drain_bytes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // program all registers while idle, with junk above the narrow fields
  task automatic program_gradient(input logic [COLOR_W-1:0] start_c,
                                  input logic [COLOR_W-1:0] target_c,
                                  input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input logic [DIR_W-1:0] dir);
    logic [COLOR_W-1:0] junk;
    junk = COLOR_W'($urandom);
    drain_bytes();
    write_reg(REG_START_COLOR, start_c);
    write_reg(REG_TARGET_COLOR, target_c);
    write_reg(REG_IMAGE_WIDTH, {junk[COLOR_W-1:DIM_W], w});
    write_reg(REG_IMAGE_HEIGHT, {~junk[COLOR_W-1:DIM_W], h});
    write_reg(REG_DIRECTION, {junk[COLOR_W-1:DIR_W], dir});
    write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_FIRST, SPARE_IDX_LAST)),
              COLOR_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one pixel transaction and hold it until taken
  task automatic offer_pixel(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_frame_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // frame size: mostly small, sometimes zero, oversize or any 13-bit value
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(15);
    case (r)
      0:       return '0;
      1:       return DIM_W'($urandom_range(8191, 4097));
      2:       return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(6, 1));
    endcase
  endfunction

  // stimulus
  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then a restart at the second pixel
    offer_pixel(1'b0);
    offer_pixel(1'b1);

    // full swing by row, 3 wide for the longest pad, through a frame end and a restart
    program_gradient(24'hFFFFFF, 24'h000000, 13'd3, 13'd2, DIR_ROW);
    repeat (7) offer_pixel(1'b0);
    offer_pixel(1'b1);

    // zero size acts as one pixel, negative delta by column
    program_gradient(24'h000000, 24'hFFFFFF, 13'd0, 13'd0, DIR_COL);
    repeat (2) offer_pixel(1'b0);

    // direction three acts as column mode
    program_gradient(24'h00FF80, 24'hFF0081, 13'd2, 13'd3, DIR_COL_ALIAS);
    repeat (2) offer_pixel(1'b0);

    // diagonal with odd deltas of both signs, then shrink below the current position
    program_gradient(24'h12AB7F, 24'hED5480, 13'd5, 13'd4, DIR_DIAG);
    repeat (7) offer_pixel(1'b0);
    program_gradient(24'h12AB7F, 24'hED5480, 13'd2, 13'd1, DIR_DIAG);
    repeat (2) offer_pixel(1'b0);

    // oversize clips to the limits
    program_gradient(24'hFFFFFF, 24'h000001, 13'd8191, 13'd5000, DIR_DIAG);
    repeat (2) offer_pixel(1'b0);

    // random settings, idling pattern changes over the phases
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES / 3) set_idling(19, 51);
      else if (p < 2 * RAND_PHASES / 3) set_idling(51, 19);
      else set_idling(0, 0);
      program_gradient(COLOR_W'($urandom), COLOR_W'($urandom), pick_dim(), pick_dim(),
                       DIR_W'($urandom));
      phase_id <= p;
      repeat (PHASE_PIXELS) offer_pixel($urandom_range(99) < RESTART_PCT);
    end

    drain_bytes();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
rtl/core/rgpg_pkg.sv
rtl/core/rgpg_front.sv
rtl/core/rgpg_fifo.sv
rtl/core/rgpg_div.sv
rtl/core/rgpg_back.sv
rtl/core/rgb_gradient_pixel_generator_core.sv
tb/rgpg_checker.sv
tb/tb_top.sv
